// ===== rtl/core/b64_pkg.sv =====
// Shared types, constants and the character-to-sextet map of the Base64 decoder.
// Used by b64_decode, b64_result_fifo and base64_decoder; no other dependencies.
package b64_pkg;

  // Result queue sizing. One accepted character can cause at most three results.
  localparam int B64_MAX_RESULTS = 3;
  localparam int B64_FIFO_DEPTH  = 8;
  localparam int B64_PTR_W       = $clog2(B64_FIFO_DEPTH);
  localparam int B64_CNT_W       = $clog2(B64_FIFO_DEPTH + 1);

  // Character codes with a special meaning.
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z   = 8'h7a;
  localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
  localparam logic [7:0] CHAR_PLUS      = 8'h2b;
  localparam logic [7:0] CHAR_MINUS     = 8'h2d;
  localparam logic [7:0] CHAR_SLASH     = 8'h2f;
  localparam logic [7:0] CHAR_UNDERLINE = 8'h5f;
  localparam logic [7:0] CHAR_PAD       = 8'h3d;

  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_SLASH      = 6'd63;

  // Group positions.
  localparam logic [1:0] GPOS_0 = 2'd0;
  localparam logic [1:0] GPOS_1 = 2'd1;
  localparam logic [1:0] GPOS_2 = 2'd2;
  localparam logic [1:0] GPOS_3 = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       error;
    logic       message_done;
    logic       run_last;
  } result_t;

  // The results caused by one character, in order, and how many are valid.
  typedef struct packed {
    logic [1:0] count;
    result_t [B64_MAX_RESULTS-1:0] res;
  } bundle_t;

  typedef struct packed {
    logic       illegal;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.illegal = 1'b0;
    s.value   = 6'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      s.value = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      s.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      s.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
      s.value = SEXTET_PLUS;
    end else if (c == CHAR_SLASH || c == CHAR_UNDERLINE) begin
      s.value = SEXTET_SLASH;
    end else begin
      s.illegal = 1'b1;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/b64_decode.sv =====
// Per-character decode step: group state registers and the logic that turns one
// character into up to three results. Depends on b64_pkg.
module b64_decode
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_code,
  input  logic       message_end,
  output bundle_t    bundle
);

  logic [1:0]  gpos_r,   gpos_nxt;
  logic [17:0] acc_r,    acc_nxt;
  logic        padded_r, padded_nxt;
  logic        err_r,    err_nxt;

  sextet_t     sx;
  logic        pad;
  logic [23:0] word;
  logic [1:0]  nbytes;
  logic        raise_err;
  logic        clear;

  assign sx  = sextet_of(char_code);
  assign pad = (char_code == CHAR_PAD);

  always_comb begin
    gpos_nxt   = gpos_r;
    acc_nxt    = acc_r;
    padded_nxt = padded_r;
    err_nxt    = err_r;
    word       = 24'd0;
    nbytes     = 2'd0;
    raise_err  = 1'b0;
    clear      = 1'b0;

    if (step) begin
      if (err_r) begin
        // Rest of a failed message is dropped until its end.
        clear = message_end;
      end else if (!pad && sx.illegal) begin
        raise_err = 1'b1;
      end else begin
        case (gpos_r)
          GPOS_0: begin
            if (pad || message_end) begin
              raise_err = 1'b1;
            end else begin
              acc_nxt  = {12'd0, sx.value};
              gpos_nxt = GPOS_1;
            end
          end
          GPOS_1: begin
            if (pad) begin
              raise_err = 1'b1;
            end else if (message_end) begin
              word   = {acc_r[5:0], sx.value, 12'd0};
              nbytes = 2'd1;
              clear  = 1'b1;
            end else begin
              acc_nxt  = {6'd0, acc_r[5:0], sx.value};
              gpos_nxt = GPOS_2;
            end
          end
          GPOS_2: begin
            if (pad) begin
              if (message_end) begin
                word   = {acc_r[11:0], 12'd0};
                nbytes = 2'd1;
                clear  = 1'b1;
              end else begin
                padded_nxt = 1'b1;
                gpos_nxt   = GPOS_3;
              end
            end else if (message_end) begin
              word   = {acc_r[11:0], sx.value, 6'd0};
              nbytes = 2'd2;
              clear  = 1'b1;
            end else begin
              acc_nxt  = {acc_r[11:0], sx.value};
              gpos_nxt = GPOS_3;
            end
          end
          default: begin
            if (padded_r) begin
              if (!(pad && message_end)) begin
                raise_err = 1'b1;
              end else begin
                word   = {acc_r[11:0], 12'd0};
                nbytes = 2'd1;
                clear  = 1'b1;
              end
            end else if (pad) begin
              if (!message_end) begin
                raise_err = 1'b1;
              end else begin
                word   = {acc_r, 6'd0};
                nbytes = 2'd2;
                clear  = 1'b1;
              end
            end else begin
              word   = {acc_r, sx.value};
              nbytes = 2'd3;
              clear  = 1'b1;
            end
          end
        endcase
      end

      if (raise_err || clear) begin
        gpos_nxt   = GPOS_0;
        acc_nxt    = 18'd0;
        padded_nxt = 1'b0;
        err_nxt    = 1'b0;
      end
      if (raise_err) begin
        err_nxt = !message_end;
      end
    end
  end

  // Build the result bundle; bytes come out most significant first.
  always_comb begin
    bundle = '0;
    if (raise_err) begin
      bundle.count                 = 2'd1;
      bundle.res[0].data_byte      = 8'd0;
      bundle.res[0].error          = 1'b1;
      bundle.res[0].message_done   = 1'b1;
      bundle.res[0].run_last       = 1'b1;
    end else begin
      bundle.count = nbytes;
      for (int k = 0; k < B64_MAX_RESULTS; k++) begin
        bundle.res[k].data_byte    = word[23 - 8*k -: 8];
        bundle.res[k].error        = 1'b0;
        bundle.res[k].run_last     = (nbytes == 2'(k + 1));
        bundle.res[k].message_done = message_end && (nbytes == 2'(k + 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpos_r   <= GPOS_0;
      acc_r    <= 18'd0;
      padded_r <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      gpos_r   <= gpos_nxt;
      acc_r    <= acc_nxt;
      padded_r <= padded_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// ===== rtl/core/b64_result_fifo.sv =====
// Result queue: takes up to three results per cycle and hands out one beat per
// cycle on the output channel while out_stall is low. Depends on b64_pkg.
module b64_result_fifo
  import b64_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t bundle,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  result_t              mem [B64_FIFO_DEPTH];
  logic [B64_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [B64_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [B64_CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [1:0]           push_n;
  logic                 pop;

  assign push_n    = push ? bundle.count : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_res   = mem[rd_ptr_r];

  // Space for a full bundle must be there before a character is taken.
  assign room = (cnt_r <= B64_CNT_W'(B64_FIFO_DEPTH - B64_MAX_RESULTS));

  assign wr_ptr_nxt = wr_ptr_r + B64_PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + B64_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + B64_CNT_W'(push_n) - B64_CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < B64_MAX_RESULTS; k++) begin
      if (push_n > 2'(k)) begin
        mem[wr_ptr_r + B64_PTR_W'(k)] <= bundle.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/base64_decoder.sv =====
// Streaming Base64 decoder, standard and URL-safe alphabets together.
// Depends on b64_pkg, b64_decode and b64_result_fifo.
//
// Input channel: one character per beat (in_char_code, in_message_end) under
// in_valid / in_stall. Output channel: one decoded byte per beat with error,
// message_done and run_last flags under out_valid / out_stall.
// A character is decoded in the cycle it is taken; its results (none to three)
// land in an eight-entry result queue; if it was empty, the first one is on
// the output in the cycle after acceptance. The input takes one character
// per cycle as long as the queue has space for three more results, and the
// output gives one byte per cycle while out_stall is low. The queue depth
// sets how long the output can be stalled before in_stall rises: with the
// queue holding six or more results the input is stalled. A malformed
// message yields a single error beat; its remaining characters are consumed
// without results up to the end mark.
// Reset (rst_n low, synchronous) empties the queue and returns the group state
// to the start of a message.
module base64_decoder
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_message_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_error,
  output logic       out_message_done,
  output logic       out_run_last
);

  logic    room;
  logic    accept;
  bundle_t bundle;
  result_t head;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  b64_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .char_code   (in_char_code),
    .message_end (in_message_end),
    .bundle      (bundle)
  );

  b64_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .bundle    (bundle),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (head)
  );

  assign out_data_byte    = head.data_byte;
  assign out_error        = head.error;
  assign out_message_done = head.message_done;
  assign out_run_last     = head.run_last;

endmodule
